FILE: hdl/mstm_pkg.sv
// Package: constants, types and pitch helpers shared by the tone mixer.
`timescale 1ns / 1ps

package mstm_pkg;

   localparam int CHANNELS   = 4;
   localparam int WAVE_STEPS = 16;
   localparam int SEMITONES  = 12;
   localparam int STEP_W     = (WAVE_STEPS > 1) ? $clog2(WAVE_STEPS) : 1;

   localparam logic [7:0] SQUARE_LEVEL = 8'd42;
   localparam logic [3:0] SILENT_PITCH = 4'd15;

   // request kinds
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_CHANGE = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   typedef struct packed {
      logic [3:0] semitone;
      logic [2:0] octave;
   } pitch_type;

   // note command broadcast to the cells
   typedef struct packed {
      logic      start;
      logic      change;
      logic      stop;
      pitch_type pitch;
   } cell_cmd_type;

   function automatic logic [9:0] tuning_word(input logic [3:0] semi);
      logic [9:0] w;
      case (semi)
         4'd0:    w = 10'd275;
         4'd1:    w = 10'd291;
         4'd2:    w = 10'd308;
         4'd3:    w = 10'd327;
         4'd4:    w = 10'd346;
         4'd5:    w = 10'd367;
         4'd6:    w = 10'd388;
         4'd7:    w = 10'd412;
         4'd8:    w = 10'd436;
         4'd9:    w = 10'd462;
         4'd10:   w = 10'd489;
         4'd11:   w = 10'd518;
         default: w = 10'd0;   // silent pitch codes
      endcase
      return w;
   endfunction

   // note / 12 via reciprocal multiply (exact for 0..127), octave saturates at 7
   function automatic pitch_type pitch_of(input logic signed [7:0] note);
      logic [14:0] prod;
      logic [3:0]  oct;
      logic [6:0]  rem;
      pitch_type   p;
      prod = 15'(note[6:0]) * 15'd171;
      oct  = prod[14:11];
      rem  = note[6:0] - 7'({3'd0, oct} * 7'd12);
      if (note[7]) begin
         p.semitone = SILENT_PITCH;
         p.octave   = 3'd0;
      end else begin
         p.semitone = rem[3:0];
         p.octave   = (oct > 4'd7) ? 3'd7 : oct[2:0];
      end
      return p;
   endfunction

endpackage

FILE: hdl/mstm_cell.sv
// One channel cell: holds a channel's state, adds its level to the passing mix.
`timescale 1ns / 1ps

module mstm_cell import mstm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               sel,
   input  cell_cmd_type       cmd,
   input  logic [30:0]        wrap_amount,
   input  logic               tick_in,
   input  logic [7:0]         mix_in,
   output logic               tick_out,
   output logic [7:0]         mix_out
);

   logic [31:0]       acc_ff, acc_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [3:0]        semi_ff, semi_in;
   logic [2:0]        oct_ff, oct_in;
   logic              active_ff, active_in;
   logic              tick_ff;
   logic [7:0]        mix_ff, mix_in_nxt;

   logic [16:0]       shifted;
   logic [31:0]       acc_sub;
   logic              wrapped;

   always_comb begin
      shifted = 17'(tuning_word(semi_ff)) << oct_ff;
      acc_sub = acc_ff - {16'd0, shifted[15:0]};
      wrapped = (acc_sub == 32'd0) || acc_sub[31];

      acc_in     = acc_ff;
      step_in    = step_ff;
      semi_in    = semi_ff;
      oct_in     = oct_ff;
      active_in  = active_ff;
      mix_in_nxt = mix_in;

      if (tick_in && active_ff) begin
         acc_in = acc_sub;
         if (wrapped) begin
            acc_in  = acc_sub + {1'b0, wrap_amount};
            step_in = (step_ff == STEP_W'(WAVE_STEPS - 1)) ? '0 : step_ff + 1'b1;
         end
         if (step_in >= STEP_W'(WAVE_STEPS / 2))
            mix_in_nxt = mix_in + SQUARE_LEVEL;
      end

      if (sel) begin
         if (cmd.start) begin
            acc_in    = {1'b0, wrap_amount};
            step_in   = '0;
            semi_in   = cmd.pitch.semitone;
            oct_in    = cmd.pitch.octave;
            active_in = 1'b1;
         end else if (cmd.change && cmd.stop) begin
            semi_in   = 4'd0;
            active_in = 1'b0;
         end else if (cmd.change) begin
            semi_in   = cmd.pitch.semitone;
            oct_in    = cmd.pitch.octave;
            active_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         step_ff   <= '0;
         semi_ff   <= '0;
         oct_ff    <= '0;
         active_ff <= 1'b0;
         tick_ff   <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         step_ff   <= step_in;
         semi_ff   <= semi_in;
         oct_ff    <= oct_in;
         active_ff <= active_in;
         tick_ff   <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      mix_ff <= mix_in_nxt;
   end

   assign tick_out = tick_ff;
   assign mix_out  = mix_ff;

endmodule

FILE: hdl/multichannel_square_tone_mixer_top.sv
// Top level: request decode, chain of channel cells, result register and skid.
`timescale 1ns / 1ps
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  req     | in  | req_tvalid/req_tready | tuser: kind; tdata: channel_sel, note_number
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: mixed_sample
//  csr     | in  | csr_valid/csr_ready   | data: wrap_amount
//
//  Note requests (start/change) update the addressed cell at the accepting
//  edge. A tick walks the cell chain one channel per cycle, passed on by
//  each cell's tick register; its mix is registered in the output or skid
//  register once it leaves the last cell.
//  Requests are held off while a tick is in the chain or a result sits in skid.
//  One finished result may wait in the output register while new requests
//  are taken; a second lands in the skid register.
//  Synchronous active-high reset silences all channels, wrap_amount = 32768.

module multichannel_square_tone_mixer_top import mstm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] channel_sel, [9:2] note_number, [15:10] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] mixed_sample
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // [30:0] wrap_amount, [31] zero
);

   logic [30:0]  wrap_ff, wrap_in;
   logic         busy_ff, busy_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_data_ff, rsp_data_in;
   logic         pend_valid_ff, pend_valid_in;
   logic [7:0]   pend_data_ff, pend_data_in;

   logic         req_fire;
   logic [1:0]   kind;
   logic [1:0]   chan;
   logic signed [7:0] note;
   cell_cmd_type cmd;

   // tick token and partial mix along the chain; index 0 feeds the first cell
   logic [CHANNELS:0] tick_chain;
   logic [7:0]        mix_chain [CHANNELS+1];
   logic [CHANNELS-1:0] sel_vec;

   assign kind = req_tuser;
   assign chan = req_tdata[1:0];
   assign note = req_tdata[9:2];

   assign req_tready = !busy_ff && !pend_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      cmd.start  = req_fire && (kind == KIND_START);
      cmd.change = req_fire && (kind == KIND_CHANGE);
      cmd.stop   = note[7];
      cmd.pitch  = pitch_of(note);
   end

   assign tick_chain[0] = req_fire && (kind == KIND_TICK);
   assign mix_chain[0]  = 8'd0;

   genvar i;
   generate
      for (i = 0; i < CHANNELS; i++) begin : g_cell
         // channel numbers past the last cell never match, so note requests to them are dropped
         assign sel_vec[i] = ({1'b0, chan} == 3'(i));

         mstm_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .sel         (sel_vec[i]),
            .cmd         (cmd),
            .wrap_amount (wrap_ff),
            .tick_in     (tick_chain[i]),
            .mix_in      (mix_chain[i]),
            .tick_out    (tick_chain[i+1]),
            .mix_out     (mix_chain[i+1])
         );
      end
   endgenerate

   always_comb begin
      wrap_in       = csr_valid ? csr_data[30:0] : wrap_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;

      if (tick_chain[0])
         busy_in = 1'b1;
      else if (tick_chain[CHANNELS])
         busy_in = 1'b0;

      if (tick_chain[CHANNELS]) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = mix_chain[CHANNELS];
         end else begin
            // output still occupied: park the result in the skid
            pend_valid_in = 1'b1;
            pend_data_in  = mix_chain[CHANNELS];
         end
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_data_in   = pend_data_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff       <= 31'd32768;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         wrap_ff       <= wrap_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      pend_data_ff <= pend_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // at most one tick token travels the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tick_chain[CHANNELS:1]))
      else $error("more than one tick in the cell chain");

   // a token in the chain implies the block is marked busy
   a_busy_cover: assert property (@(posedge clock) disable iff (reset)
      (tick_chain[CHANNELS:1] != '0) |-> busy_ff)
      else $error("tick in chain while not busy");

   // an accepted tick reaches the end of the chain, passed on by each cell's tick register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      tick_chain[0] |-> ##CHANNELS tick_chain[CHANNELS])
      else $error("tick did not complete on time");

   // the skid only fills behind a waiting output
   a_skid: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("skid holds data with output empty");

endmodule

FILE: tb/multichannel_square_tone_mixer_top_tb.sv
// Testbench for the tone mixer: random and directed requests checked against a channel model.
`timescale 1ns / 1ps

module multichannel_square_tone_mixer_top_tb;
   import mstm_pkg::*;

   // kind code the block must swallow without a result
   localparam logic [1:0]  KIND_UNUSED      = 2'd3;
   // a note request updates its cell at once; a tick walks the chain once
   localparam int          SETTLE_CYCLES    = CHANNELS + 4;
   localparam int          RANDOM_PER_PHASE = 450;
   localparam int          SEGMENTS         = 3;
   localparam logic [30:0] WRAP_MAX         = 31'h7FFF_FFFF;

   // phase decrement per semitone at octave 0
   localparam int unsigned NOTE_STEP [SEMITONES] =
      '{275, 291, 308, 327, 346, 367, 388, 412, 436, 462, 489, 518};

   typedef struct {
      logic [31:0]       phase;
      logic [STEP_W-1:0] step;
      logic [3:0]        semi;
      logic [2:0]        octave;
      logic              playing;
   } voice_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [1:0] channel_sel, [9:2] note_number, [15:10] zero
   logic [1:0]  req_tuser  = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] mixed_sample
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data   = '0;   // [30:0] wrap_amount, [31] zero

   // channel model and the mixed samples still owed by the block
   voice_type   voices [CHANNELS];
   logic [30:0] wrap_amount_m;
   logic [7:0]  mix_expected [$];

   int send_idle_pct;
   int recv_idle_pct;
   int failures;
   int requests_sent;
   int ticks_sent;
   int results_checked;
   int wrap_writes;

   multichannel_square_tone_mixer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic void clear_voices();
      for (int c = 0; c < CHANNELS; c++) begin
         voices[c] = '{phase: '0, step: '0, semi: '0, octave: '0, playing: 1'b0};
      end
      wrap_amount_m = 31'd32768;
   endfunction

   // negative notes select the silent pitch; octaves above 7 saturate
   function automatic void load_pitch(input int chan, input logic signed [7:0] note);
      int n;
      n = note;
      if (n < 0) begin
         voices[chan].semi   = SILENT_PITCH;
         voices[chan].octave = 3'd0;
      end else begin
         voices[chan].semi   = 4'(n % SEMITONES);
         voices[chan].octave = (n / SEMITONES > 7) ? 3'd7 : 3'(n / SEMITONES);
      end
   endfunction

   function automatic void apply_note_request(input logic [1:0] kind, input logic [1:0] chan,
                                              input logic [7:0] note);
      if (int'(chan) >= CHANNELS) return;
      if (kind == KIND_START) begin
         voices[chan].phase   = {1'b0, wrap_amount_m};
         voices[chan].step    = '0;
         load_pitch(chan, note);
         voices[chan].playing = 1'b1;
      end else if (kind == KIND_CHANGE) begin
         if (!note[7]) begin
            load_pitch(chan, note);
            voices[chan].playing = 1'b1;
         end else begin
            // stop keeps the octave, only the semitone clears
            voices[chan].semi    = '0;
            voices[chan].playing = 1'b0;
         end
      end
   endfunction

   // one sample tick over all channels; returns the mixed sample
   function automatic logic [7:0] advance_mixer();
      logic [31:0] acc;
      logic [31:0] decrement;
      logic [7:0]  mix;
      mix = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (voices[c].playing) begin
            decrement = '0;
            if (voices[c].semi < SEMITONES)
               decrement = (32'(NOTE_STEP[voices[c].semi]) << voices[c].octave) & 32'hFFFF;
            acc = voices[c].phase - decrement;
            if (acc == 32'd0 || acc[31]) begin
               acc += {1'b0, wrap_amount_m};
               voices[c].step = STEP_W'((voices[c].step + 1) % WAVE_STEPS);
            end
            voices[c].phase = acc;
            if (voices[c].step >= WAVE_STEPS / 2) mix += SQUARE_LEVEL;
         end
      end
      return mix;
   endfunction

   // ---------------------------------------------------------- result side

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_mix
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mix_expected.size() == 0) begin
            $error("mixed_sample expected none got %0d", rsp_tdata);
            failures++;
         end else begin
            want = mix_expected.pop_front();
            results_checked++;
            if (rsp_tdata !== want) begin
               $error("mixed_sample expected %0d got %0d", want, rsp_tdata);
               failures++;
            end
         end
      end
   end

   // ------------------------------------------------------------- drivers

   // valid stays high after a handshake; it only drops in an idle cycle
   task automatic send_request(input logic [1:0] kind, input logic [1:0] chan,
                               input logic [7:0] note);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, note, chan};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (kind == KIND_TICK) begin
         mix_expected.push_back(advance_mixer());
         ticks_sent++;
      end else begin
         apply_note_request(kind, chan, note);
      end
   endtask

   // drop valid, let every owed sample out, then give note requests time to land
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (mix_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_wrap(input logic [30:0] value);
      csr_valid <= 1'b1;
      csr_data  <= {1'b0, value};
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      wrap_amount_m  = value;
      wrap_writes++;
   endtask

   // small wrap values make the wave steps turn over quickly
   function automatic logic [30:0] pick_wrap();
      case ($urandom_range(5, 0))
         0, 1:    return 31'($urandom_range(64, 1));
         2, 3:    return 31'($urandom_range(4096, 65));
         4:       return 31'($urandom_range(65536, 4097));
         default: return 31'($urandom);
      endcase
   endfunction

   // ticks dominate; notes mostly in range, some past 95, some negative
   task automatic send_random_request(output bit counted);
      int         roll;
      logic [1:0] kind;
      logic [7:0] note;
      roll = $urandom_range(99, 0);
      if (roll < 55)      kind = KIND_TICK;
      else if (roll < 75) kind = KIND_START;
      else if (roll < 95) kind = KIND_CHANGE;
      else                kind = KIND_UNUSED;
      roll = $urandom_range(99, 0);
      if (roll < 70)      note = 8'($urandom_range(95, 0));
      else if (roll < 80) note = 8'($urandom_range(127, 96));
      else if (roll < 90) note = 8'hFF;
      else                note = 8'($urandom_range(255, 128));
      send_request(kind, 2'($urandom_range(3, 0)), note);
      counted = (kind != KIND_UNUSED);
   endtask

   // ---------------------------------------------------------------- tests

   // silent channels after reset, then one note at the reset wrap amount
   task automatic test_reset_state();
      send_request(KIND_TICK, 2'd0, 8'd0);
      send_request(KIND_TICK, 2'd3, 8'd0);
      send_request(KIND_START, 2'd0, 8'd60);
      send_request(KIND_TICK, 2'd0, 8'd0);
      send_request(KIND_TICK, 2'd0, 8'd0);
   endtask

   // wrap of 1 flips the wave step every tick, so levels show quickly
   task automatic test_note_edges();
      wait_idle();
      write_wrap(31'd1);
      send_request(KIND_START, 2'd0, 8'd0);
      send_request(KIND_START, 2'd1, 8'd95);
      send_request(KIND_START, 2'd2, 8'd127);   // octave saturates
      send_request(KIND_START, 2'd3, 8'hFF);    // silent pitch holds its level
      repeat (4) send_request(KIND_TICK, 2'd0, 8'd0);
      send_request(KIND_CHANGE, 2'd0, 8'h80);   // stop, octave kept
      send_request(KIND_CHANGE, 2'd1, 8'd11);
      send_request(KIND_UNUSED, 2'd3, 8'd127);  // ignored
      repeat (4) send_request(KIND_TICK, 2'd1, 8'd0);
      send_request(KIND_CHANGE, 2'd0, 8'd40);   // resume with old phase
      send_request(KIND_CHANGE, 2'd3, 8'hFF);
      repeat (3) send_request(KIND_TICK, 2'd2, 8'd0);
   endtask

   task automatic test_wrap_extremes();
      wait_idle();
      write_wrap(WRAP_MAX);
      send_request(KIND_START, 2'd0, 8'd84);
      repeat (2) send_request(KIND_TICK, 2'd0, 8'd0);
      wait_idle();
      write_wrap(31'd0);                        // adds nothing back on a wrap
      send_request(KIND_START, 2'd1, 8'd0);
      repeat (2) send_request(KIND_TICK, 2'd0, 8'd0);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      int sent;
      bit counted;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_idle();
         write_wrap(pick_wrap());
         sent = 0;
         while (sent < RANDOM_PER_PHASE / SEGMENTS) begin
            send_random_request(counted);
            if (counted) sent++;
         end
      end
   endtask

   initial begin
      clear_voices();
      failures        = 0;
      requests_sent   = 0;
      ticks_sent      = 0;
      results_checked = 0;
      wrap_writes     = 0;
      send_idle_pct   = 17;
      recv_idle_pct   = 88;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_note_edges();
      test_wrap_extremes();
      test_random_traffic(17, 88);
      test_random_traffic(88, 17);
      test_random_traffic(0, 0);
      wait_idle();

      $display("Sent %0d requests (%0d ticks) over %0d wrap_amount settings",
               requests_sent, ticks_sent, wrap_writes);
      $display("Compared %0d mixed samples, %0d mismatches", results_checked, failures);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: multichannel_square_tone_mixer_top.f
hdl/mstm_pkg.sv
hdl/mstm_cell.sv
hdl/multichannel_square_tone_mixer_top.sv
tb/multichannel_square_tone_mixer_top_tb.sv
